[rtl/jbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbl_pkg
// Shared types, codes and character classes for the JSON byte lexer.
// ----------------------------------------------------------------------------
package jbl_pkg;

  // lexer modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STR  = 3'd1;
  localparam logic [2:0] MODE_NUM  = 3'd2;
  localparam logic [2:0] MODE_KEY  = 3'd3;
  localparam logic [2:0] MODE_ERR  = 3'd4;

  // event codes
  localparam logic [2:0] EV_LIT    = 3'd0;
  localparam logic [2:0] EV_TOKEND = 3'd1;
  localparam logic [2:0] EV_PUNCT  = 3'd2;
  localparam logic [2:0] EV_END    = 3'd3;
  localparam logic [2:0] EV_ERR    = 3'd4;

  // token kinds
  localparam logic [3:0] KIND_NONE     = 4'd0;
  localparam logic [3:0] KIND_COMMA    = 4'd0;
  localparam logic [3:0] KIND_COLON    = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_LCURLY   = 4'd4;
  localparam logic [3:0] KIND_RCURLY   = 4'd5;
  localparam logic [3:0] KIND_STR      = 4'd6;
  localparam logic [3:0] KIND_NUM      = 4'd7;
  localparam logic [3:0] KIND_KEY      = 4'd8;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_INVALID  = 2'd2;
  localparam logic [1:0] ERR_UNCLOSED = 2'd3;

  // special bytes
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LCURLY   = 8'h7B;
  localparam logic [7:0] CH_RCURLY   = 8'h7D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_DOT      = 8'h2E;

  // one result item
  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] token_kind;
    logic [7:0] char_value;
    logic [1:0] error_code;
    logic       last_of_run;
  } result_t;

  // outcome of a byte seen between tokens
  typedef struct packed {
    logic       hit;
    result_t    res;
    logic [2:0] mode;
  } idle_t;

  function automatic result_t mk_res(logic [2:0] ev, logic [3:0] kind,
                                     logic [7:0] ch, logic [1:0] err);
    result_t r;
    r.event_res   = ev;
    r.token_kind  = kind;
    r.char_value  = ch;
    r.error_code  = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  // classify a byte that starts a fresh token
  function automatic idle_t idle_byte(logic [7:0] c);
    idle_t o;
    o.hit  = 1'b1;
    o.mode = MODE_IDLE;
    o.res  = mk_res(EV_PUNCT, KIND_NONE, 8'd0, ERR_NONE);
    case (c)
      CH_COMMA:    o.res.token_kind = KIND_COMMA;
      CH_COLON:    o.res.token_kind = KIND_COLON;
      CH_LBRACKET: o.res.token_kind = KIND_LBRACKET;
      CH_RBRACKET: o.res.token_kind = KIND_RBRACKET;
      CH_LCURLY:   o.res.token_kind = KIND_LCURLY;
      CH_RCURLY:   o.res.token_kind = KIND_RCURLY;
      CH_QUOTE: begin
        o.hit  = 1'b0;
        o.mode = MODE_STR;
      end
      default: begin
        if (is_space(c)) begin
          o.hit = 1'b0;
        end else if (is_digit(c)) begin
          o.mode = MODE_NUM;
          o.res  = mk_res(EV_LIT, KIND_NUM, c, ERR_NONE);
        end else if (is_letter(c)) begin
          o.mode = MODE_KEY;
          o.res  = mk_res(EV_LIT, KIND_KEY, c, ERR_NONE);
        end else begin
          o.mode = MODE_ERR;
          o.res  = mk_res(EV_ERR, KIND_NONE, 8'd0, ERR_INVALID);
        end
      end
    endcase
    return o;
  endfunction

endpackage

[rtl/json_byte_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_byte_lexer
// Splits JSON text, one byte per request, into lexical events.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready) carries one text byte or an end marker
//   (end_of_input set, byte_value ignored)
// - output channel (out_valid/out_ready) carries lexical events: literal
//   bytes, literal token ends, punctuation, clean end and errors; each
//   request makes zero, one or two events, last_of_run flags the final one
// - the request is classified in the cycle it is accepted and its events are
//   written to a four-entry result queue; the first event is presented from
//   the queue head once it is registered there and earlier events have drained
// - throughput is one request per cycle while requests make at most one
//   event each and the receiver is not stalling; a request that makes two
//   events drains one event per pop, so the queue drain rate sets the sustained rate
// - in_ready is high while the queue has room for two events, so the lexer
//   keeps taking requests while earlier events wait on a stalled receiver
// - a stalled receiver simply holds the queue head; nothing is dropped
// - after an invalid byte all bytes are skipped until the end marker, which
//   also clears the lexer state
// - synchronous reset empties the queue and returns the lexer to idle with
//   no byte seen
// ----------------------------------------------------------------------------
module json_byte_lexer import jbl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [3:0] token_kind,
  output logic [7:0] char_value,
  output logic [1:0] error_code,
  output logic       last_of_run
);

  logic [2:0] lexer_mode;
  logic [2:0] lexer_mode_next;
  logic       seen_any_byte;
  logic       seen_any_byte_next;

  result_t    fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  logic       accept;
  logic       pop;
  logic [1:0] n_res;
  result_t    r0;
  result_t    r1;
  idle_t      idl;
  logic [2:0] mode_cur;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  // classify the request against the current mode
  always_comb begin
    mode_cur           = (lexer_mode > MODE_ERR) ? MODE_IDLE : lexer_mode;
    idl                = idle_byte(byte_value);
    n_res              = 2'd0;
    r0                 = mk_res(EV_END, KIND_NONE, 8'd0, ERR_NONE);
    r1                 = mk_res(EV_END, KIND_NONE, 8'd0, ERR_NONE);
    lexer_mode_next    = mode_cur;
    seen_any_byte_next = 1'b1;
    if (end_of_input) begin
      lexer_mode_next    = MODE_IDLE;
      seen_any_byte_next = 1'b0;
      if (mode_cur == MODE_ERR) begin
        n_res = 2'd0;
      end else if (!seen_any_byte) begin
        n_res = 2'd1;
        r0    = mk_res(EV_ERR, KIND_NONE, 8'd0, ERR_EMPTY);
      end else if (mode_cur == MODE_STR) begin
        n_res = 2'd1;
        r0    = mk_res(EV_ERR, KIND_NONE, 8'd0, ERR_UNCLOSED);
      end else if (mode_cur == MODE_NUM || mode_cur == MODE_KEY) begin
        n_res = 2'd2;
        r0    = mk_res(EV_TOKEND, (mode_cur == MODE_NUM) ? KIND_NUM : KIND_KEY,
                       8'd0, ERR_NONE);
      end else begin
        n_res = 2'd1;
      end
    end else begin
      case (mode_cur)
        MODE_ERR: begin
          n_res = 2'd0;
        end
        MODE_STR: begin
          n_res = 2'd1;
          if (byte_value == CH_QUOTE) begin
            lexer_mode_next = MODE_IDLE;
            r0 = mk_res(EV_TOKEND, KIND_STR, 8'd0, ERR_NONE);
          end else begin
            r0 = mk_res(EV_LIT, KIND_STR, byte_value, ERR_NONE);
          end
        end
        MODE_NUM, MODE_KEY: begin
          if ((mode_cur == MODE_NUM &&
               (is_digit(byte_value) || byte_value == CH_DOT)) ||
              (mode_cur == MODE_KEY && is_letter(byte_value))) begin
            n_res = 2'd1;
            r0 = mk_res(EV_LIT, (mode_cur == MODE_NUM) ? KIND_NUM : KIND_KEY,
                        byte_value, ERR_NONE);
          end else begin
            // token ends, the byte starts over as a fresh byte
            r0 = mk_res(EV_TOKEND, (mode_cur == MODE_NUM) ? KIND_NUM : KIND_KEY,
                        8'd0, ERR_NONE);
            r1 = idl.res;
            n_res = idl.hit ? 2'd2 : 2'd1;
            lexer_mode_next = idl.mode;
          end
        end
        default: begin
          r0 = idl.res;
          n_res = idl.hit ? 2'd1 : 2'd0;
          lexer_mode_next = idl.mode;
        end
      endcase
    end
    r0.last_of_run = (n_res == 2'd1);
    r1.last_of_run = 1'b1;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      lexer_mode    <= MODE_IDLE;
      seen_any_byte <= 1'b0;
    end else if (accept) begin
      lexer_mode    <= lexer_mode_next;
      seen_any_byte <= seen_any_byte_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      fifo[wr_ptr] <= r0;
    end
    if (accept && n_res == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= r1;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + n_res;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
    end
  end

  // handshakes and output fields
  assign in_ready    = (count <= 3'd2);
  assign out_valid   = (count != 3'd0);
  assign event_res   = fifo[rd_ptr].event_res;
  assign token_kind  = fifo[rd_ptr].token_kind;
  assign char_value  = fifo[rd_ptr].char_value;
  assign error_code  = fifo[rd_ptr].error_code;
  assign last_of_run = fifo[rd_ptr].last_of_run;

endmodule

[rtl/jbl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbl_checker
// Port-level checks for the JSON byte lexer, bound to the top level.
// ----------------------------------------------------------------------------
module jbl_checker import jbl_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] byte_value,
  input logic       end_of_input,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic [3:0] token_kind,
  input logic [7:0] char_value,
  input logic [1:0] error_code,
  input logic       last_of_run
);

  // a stalled event stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) &&
      $stable(char_value))
    else $error("output event dropped while stalled");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // error code present exactly on error events
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_res == EV_ERR) == (error_code != ERR_NONE)))
    else $error("error code does not match event");

  // literal byte only on literal events
  a_char_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_LIT |-> char_value == 8'd0)
    else $error("byte on non-literal event");

  // end and error events close their request
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_END || event_res == EV_ERR) |-> last_of_run)
    else $error("end or error event not last of its request");

endmodule

bind json_byte_lexer jbl_checker u_jbl_checker (.*);
